>>> hw/rtl/rce_pkg.sv
package rce_pkg;

   localparam int ROW_W     = 32;
   localparam int ROW_IDX_W = 5;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 8;
   localparam int MODE_W    = 2;

   localparam logic [MODE_W-1:0] MODE_REFLEXIVE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRANSITIVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SYMMETRIC  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CLOSURE_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT   = 4'd1;

   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_TRANSITIVE;
   localparam logic [CNT_W-1:0]  NODES_RESET = 6'd32;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CLOSE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      LOP_HOLD,
      LOP_LOAD,
      LOP_REFL,
      LOP_SYMM,
      LOP_WARSH
   } lane_op_type;

   typedef struct packed {
      lane_op_type          op;
      logic [ROW_IDX_W-1:0] idx;
   } lane_ctl_type;

   typedef struct packed {
      logic             req_ready;
      logic             rsp_valid;
      logic             last;
      logic [CNT_W-1:0] nodes;
      logic [CNT_W-1:0] cnt;
   } seq_status_type;

   // Column mask for n active nodes (n in 1..32).
   function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] n);
      logic [ROW_W:0] one_hot;
      one_hot = (ROW_W+1)'(1) << n;
      return (n >= CNT_W'(ROW_W)) ? {ROW_W{1'b1}} : (one_hot[ROW_W-1:0] - ROW_W'(1));
   endfunction

endpackage

>>> hw/rtl/rce_if.sv
interface rce_req_if;
   import rce_pkg::*;
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_bits;
   modport source (output valid, output row_bits, input ready);
   modport sink   (input valid, input row_bits, output ready);
endinterface

interface rce_rsp_if;
   import rce_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     closed_row;
   logic [ROW_IDX_W-1:0] row_number;
   logic                 last_row;
   modport source (output valid, output closed_row, output row_number, output last_row,
                   input ready);
   modport sink   (input valid, input closed_row, input row_number, input last_row,
                   output ready);
endinterface

interface rce_csr_if;
   import rce_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/relation_closure_engine_unit.sv
// Relation closure engine: Boolean relation matrix closure, N x N with N up to 32.
// Channels: req_bus carries one matrix row per beat (row_bits, bit j = column j);
// rsp_bus returns the closed matrix one row per beat with row_number and last_row
// set on row N-1; csr_bus writes closure_mode (index 0) and node_count (index 1),
// always ready; users must use it only while no matrix is in flight (unchecked).
// Flow: N load beats fill the lane registers, then one close phase runs:
// reflexive and symmetric apply as a single update, transitive runs N Warshall
// pivots (one pivot per cycle, all rows updated by their own lane), and any other
// mode leaves the matrix unchanged. N response beats follow. The single shared
// lane array holds one matrix at a time: a new matrix loads only after the last
// row of the previous one is taken.
// req_bus.ready is high only during the load phase. A stalled rsp_bus holds the
// current row, row counter and matrix; nothing advances until the beat is taken.
// Reset (synchronous) returns to the load phase with an empty load count,
// closure_mode = transitive and node_count = 32; matrix rows are not cleared
// since each row in use is loaded before it is read.
module relation_closure_engine_unit
   import rce_pkg::*;
#(
   parameter int MAX_NODES = 32
) (
   input  logic      clock,
   input  logic      reset,
   rce_req_if.sink   req_bus,
   rce_rsp_if.source rsp_bus,
   rce_csr_if.sink   csr_bus
);

   localparam int LIM = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

   logic [MODE_W-1:0] closure_mode_ff, closure_mode_in;
   logic [CNT_W-1:0]  node_count_ff, node_count_in;

   lane_ctl_type     lane_ctl;
   seq_status_type   status;
   logic [ROW_W-1:0] rows [LIM];
   logic [ROW_W-1:0] col_bits [LIM];
   logic [ROW_W-1:0] load_row;
   logic [ROW_W-1:0] pivot_row;
   logic             req_fire;
   logic             rsp_fire;

   // configuration registers; unknown indexes are dropped
   assign csr_bus.ready = 1'b1;

   always_comb begin
      closure_mode_in = closure_mode_ff;
      node_count_in   = node_count_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == REG_CLOSURE_MODE) begin
            closure_mode_in = csr_bus.data[MODE_W-1:0];
         end else if (csr_bus.index == REG_NODE_COUNT) begin
            node_count_in = csr_bus.data[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closure_mode_ff <= MODE_RESET;
         node_count_ff   <= NODES_RESET;
      end else begin
         closure_mode_ff <= closure_mode_in;
         node_count_ff   <= node_count_in;
      end
   end

   assign req_fire      = req_bus.valid & req_bus.ready;
   assign rsp_fire      = rsp_bus.valid & rsp_bus.ready;
   assign req_bus.ready = status.req_ready;
   assign rsp_bus.valid = status.rsp_valid;

   // drop columns at or above N on the way in
   assign load_row = req_bus.row_bits & col_mask(status.nodes);

   rce_seq #(.LIM(LIM)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .rsp_fire     (rsp_fire),
      .closure_mode (closure_mode_ff),
      .node_count   (node_count_ff),
      .lane_ctl     (lane_ctl),
      .status       (status)
   );

   // transpose wiring for the symmetric closure; stale rows past N only reach
   // columns past N, which the output mask clears
   for (genvar i = 0; i < LIM; i++) begin : g_lane
      for (genvar k = 0; k < ROW_W; k++) begin : g_col
         if (k < LIM) begin : g_used
            assign col_bits[i][k] = rows[k][i];
         end else begin : g_unused
            assign col_bits[i][k] = 1'b0;
         end
      end

      rce_lane #(.LANE_ID(i)) u_lane (
         .clock     (clock),
         .lane_ctl  (lane_ctl),
         .load_row  (load_row),
         .pivot_row (pivot_row),
         .col_bits  (col_bits[i]),
         .row       (rows[i])
      );
   end

   rce_merge #(.LIM(LIM)) u_merge (
      .rows       (rows),
      .status     (status),
      .pivot_row  (pivot_row),
      .closed_row (rsp_bus.closed_row),
      .row_number (rsp_bus.row_number),
      .last_row   (rsp_bus.last_row)
   );

endmodule

>>> hw/rtl/rce_lane.sv
module rce_lane
   import rce_pkg::*;
#(
   parameter int LANE_ID = 0
) (
   input  logic             clock,
   input  lane_ctl_type     lane_ctl,
   input  logic [ROW_W-1:0] load_row,
   input  logic [ROW_W-1:0] pivot_row,
   input  logic [ROW_W-1:0] col_bits,
   output logic [ROW_W-1:0] row
);

   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      unique case (lane_ctl.op)
         LOP_LOAD: begin
            if (lane_ctl.idx == ROW_IDX_W'(LANE_ID)) row_in = load_row;
         end
         LOP_REFL: row_in = row_ff | (ROW_W'(1) << LANE_ID);
         LOP_SYMM: row_in = row_ff | col_bits;
         // Warshall: pull in the pivot row when this row reaches the pivot
         LOP_WARSH: begin
            if (row_ff[lane_ctl.idx]) row_in = row_ff | pivot_row;
         end
         default: row_in = row_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule

>>> hw/rtl/rce_seq.sv
module rce_seq
   import rce_pkg::*;
#(
   parameter int LIM = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              rsp_fire,
   input  logic [MODE_W-1:0] closure_mode,
   input  logic [CNT_W-1:0]  node_count,
   output lane_ctl_type      lane_ctl,
   output seq_status_type    status
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0] nodes;
   logic [CNT_W-1:0] load_idx;
   logic [CNT_W-1:0] load_next;
   logic             at_end;

   always_comb begin
      if (node_count == '0) nodes = CNT_W'(1);
      else if (node_count > CNT_W'(LIM)) nodes = CNT_W'(LIM);
      else nodes = node_count;
   end

   // restart the load when the node count shrank under the fill level
   assign load_idx  = (load_cnt_ff >= nodes) ? '0 : load_cnt_ff;
   assign load_next = load_idx + CNT_W'(1);
   assign at_end    = (cnt_ff == nodes - CNT_W'(1));

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      load_cnt_in     = load_cnt_ff;
      lane_ctl.op     = LOP_HOLD;
      lane_ctl.idx    = cnt_ff[ROW_IDX_W-1:0];
      status.req_ready = 1'b0;
      status.rsp_valid = 1'b0;
      status.last      = at_end;
      status.nodes     = nodes;
      status.cnt       = cnt_ff;
      unique case (state_ff)
         ST_LOAD: begin
            status.req_ready = 1'b1;
            lane_ctl.idx     = load_idx[ROW_IDX_W-1:0];
            if (req_fire) begin
               lane_ctl.op = LOP_LOAD;
               if (load_next >= nodes) begin
                  load_cnt_in = '0;
                  cnt_in      = '0;
                  state_in    = ST_CLOSE;
               end else begin
                  load_cnt_in = load_next;
               end
            end
         end
         ST_CLOSE: begin
            unique case (closure_mode)
               MODE_REFLEXIVE: begin
                  lane_ctl.op = LOP_REFL;
                  state_in    = ST_EMIT;
               end
               MODE_SYMMETRIC: begin
                  lane_ctl.op = LOP_SYMM;
                  state_in    = ST_EMIT;
               end
               MODE_TRANSITIVE: begin
                  lane_ctl.op = LOP_WARSH;
                  if (at_end) begin
                     cnt_in   = '0;
                     state_in = ST_EMIT;
                  end else begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_EMIT: begin
            status.rsp_valid = 1'b1;
            if (rsp_fire) begin
               if (at_end) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         load_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         load_cnt_ff <= load_cnt_in;
      end
   end

endmodule

>>> hw/rtl/rce_merge.sv
module rce_merge
   import rce_pkg::*;
#(
   parameter int LIM = 32
) (
   input  logic [ROW_W-1:0]     rows [LIM],
   input  seq_status_type       status,
   output logic [ROW_W-1:0]     pivot_row,
   output logic [ROW_W-1:0]     closed_row,
   output logic [ROW_IDX_W-1:0] row_number,
   output logic                 last_row
);

   localparam int SEL_W = $clog2(LIM);

   logic [SEL_W-1:0] sel;

   // one shared row select: pivot during Warshall passes, output row during emit
   assign sel        = status.cnt[SEL_W-1:0];
   assign pivot_row  = rows[sel];
   assign closed_row = rows[sel] & col_mask(status.nodes);
   assign row_number = status.cnt[ROW_IDX_W-1:0];
   assign last_row   = status.last;

endmodule
